/* rtl/ray_box_face_hit_test_core_assert.svh */
// Assertion macros for the ray box face hit test core.
// Used by the top level; no other dependencies.
`ifndef RAY_BOX_FACE_HIT_TEST_CORE_ASSERT_SVH
`define RAY_BOX_FACE_HIT_TEST_CORE_ASSERT_SVH
`ifndef SYNTH
`define RBF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RBF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rbf_pkg.sv */
// Package for the ray box face hit test core: widths, face table, types.
// No dependencies.
`default_nettype none
package rbf_pkg;
    localparam int CoordWidth = 16;
    localparam int FracBits = 8;
    localparam int RangeWidth = 15;
    localparam int NumCorners = 8;
    localparam int NumFaces = 6;
    localparam int AddrWidth = 6;

    typedef logic [2:0] corner_idx_t;

    function automatic corner_idx_t face_corner(input int f, input int k);
        corner_idx_t r;
        r = 3'd0;
        case (f)
            0: r = (k == 0) ? 3'd0 : (k == 1) ? 3'd1 : 3'd3;
            1: r = (k == 0) ? 3'd4 : (k == 1) ? 3'd5 : 3'd7;
            2: r = (k == 0) ? 3'd4 : (k == 1) ? 3'd0 : 3'd7;
            3: r = (k == 0) ? 3'd1 : (k == 1) ? 3'd5 : 3'd2;
            4: r = (k == 0) ? 3'd3 : (k == 1) ? 3'd2 : 3'd7;
            default: r = (k == 0) ? 3'd0 : (k == 1) ? 3'd1 : 3'd4;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/rbf_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface rbf_if #(
    parameter int Width = 1
);
    logic valid;
    logic ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ray_box_face_hit_test_core.sv */
// Top level of the ray box face hit test core: config, six face pipes, control.
// Depends on rbf_pkg, rbf_if, rbf_cfg, rbf_face and the assertion header.
//
// Channel | Dir | Payload
// ray     | in  | origin_x/y/z, dir_x/y/z, ray_range
// result  | out | hit
//
// One ray per cycle unless the result side stalls.
// The depth is set by the face pipeline of multiply and add stages.
// A stall on the result side freezes the whole pipeline; nothing is lost.
// Reset clears the valid bits and the corner registers.
`default_nettype none
`include "ray_box_face_hit_test_core_assert.svh"
module ray_box_face_hit_test_core #(
    parameter int COORD_WIDTH = rbf_pkg::CoordWidth,
    parameter int FRAC_BITS = rbf_pkg::FracBits
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rbf_if.sink ray,
    rbf_if.source result,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [rbf_pkg::AddrWidth-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic pready
);
    localparam int CW = COORD_WIDTH;
    localparam int RW = rbf_pkg::RangeWidth;
    localparam int Depth = 7;

    logic [rbf_pkg::NumCorners-1:0][3*CW-1:0] corners;
    logic signed [CW-1:0] pts [rbf_pkg::NumCorners][3];
    logic signed [CW-1:0] o [3], d [3];
    logic [RW-1:0] rng;
    logic [rbf_pkg::NumFaces-1:0] face_hit;
    logic [Depth-1:0] valid_reg;
    logic en;

    rbf_cfg #(.CW(CW)) u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .corners(corners)
    );

    always_comb
    begin
        for (int c = 0; c < rbf_pkg::NumCorners; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pts[c][k] = corners[c][k*CW +: CW];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            o[k] = ray.data[k*CW +: CW];
            d[k] = ray.data[(3+k)*CW +: CW];
        end
        rng = ray.data[6*CW +: RW];
    end

    assign en = !valid_reg[Depth-1] || result.ready;
    assign ray.ready = en;
    assign result.valid = valid_reg[Depth-1];
    assign result.data = (|face_hit);

    for (genvar f = 0; f < rbf_pkg::NumFaces; f++) begin : g_face
        rbf_face #(.CW(CW), .FB(FRAC_BITS), .RW(RW)) u_face (
            .clk(clk), .en(en),
            .p0(pts[rbf_pkg::face_corner(f, 0)]),
            .p1(pts[rbf_pkg::face_corner(f, 1)]),
            .p3(pts[rbf_pkg::face_corner(f, 2)]),
            .o(o), .d(d), .range_in(rng), .hit(face_hit[f])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[Depth-2:0], ray.valid};
        end
    end

    `RBF_ASSERT_NEXT(a_stall_hold, clk, rst_n, result.valid && !result.ready, result.valid)
    `RBF_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !result.valid, ray.ready)
    `RBF_ASSERT_NEXT(a_hold_stage, clk, rst_n, !en, $stable(valid_reg))
endmodule
`default_nettype wire

/* rtl/rbf_cfg.sv */
// APB-style configuration register file holding the eight box corners.
// Depends on rbf_pkg.
`default_nettype none
module rbf_cfg #(
    parameter int CW = rbf_pkg::CoordWidth
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [rbf_pkg::AddrWidth-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic pready,
    output logic [rbf_pkg::NumCorners-1:0][3*CW-1:0] corners
);
    logic [rbf_pkg::NumCorners-1:0][3*CW-1:0] corner_reg;
    logic [2:0] idx;

    assign idx = paddr[5:3];
    assign pready = 1'b1;
    assign corners = corner_reg;
    assign prdata = 64'(corner_reg[idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            corner_reg[idx] <= pwdata[3*CW-1:0];
        end
    end
endmodule
`default_nettype wire

/* rtl/rbf_face.sv */
// Pipelined hit test of one ray against one face, by cross-multiplication.
// Depends on nothing beyond its parameters.
`default_nettype none
module rbf_face #(
    parameter int CW = 16,
    parameter int FB = 8,
    parameter int RW = 15
) (
    input  wire logic clk,
    input  wire logic en,
    input  wire logic signed [CW-1:0] p0 [3],
    input  wire logic signed [CW-1:0] p1 [3],
    input  wire logic signed [CW-1:0] p3 [3],
    input  wire logic signed [CW-1:0] o [3],
    input  wire logic signed [CW-1:0] d [3],
    input  wire logic [RW-1:0] range_in,
    output logic hit
);
    localparam int EW = CW + 1;
    localparam int NW = 2 * EW + 1;
    localparam int DW = CW + NW + 2;
    localparam int LW = 2 * EW + 2;
    localparam int DEW = CW + EW + 2;
    localparam int SW = DW + LW + 2;
    localparam int HW = DW / 2;
    localparam int HHW = DW - HW;
    localparam int PW = HHW + LW + 2;

    // Stage 1: edges and offsets.
    logic signed [EW-1:0] e1_reg [3], e2_reg [3], w_reg [3];
    logic signed [CW-1:0] d1_reg [3];
    logic [RW-1:0] r1_reg;
    // Stage 2: normal.
    logic signed [NW-1:0] n_reg [3];
    logic signed [EW-1:0] e1b_reg [3], e2b_reg [3], w2_reg [3];
    logic signed [CW-1:0] d2_reg [3];
    logic [RW-1:0] r2_reg;
    // Stage 3: dot products.
    logic signed [DW-1:0] den_reg, num_reg;
    logic signed [LW-1:0] l1s_reg, l2s_reg, rp1_reg, rp2_reg;
    logic signed [DEW-1:0] de1_reg, de2_reg;
    logic [RW-1:0] r3_reg;
    // Stage 4: sign fold.
    logic signed [DW-1:0] den4_reg, num4_reg;
    logic ok4_reg;
    logic signed [LW-1:0] l1s4_reg, l2s4_reg, rp14_reg, rp24_reg;
    logic signed [DEW-1:0] de14_reg, de24_reg;
    logic [RW-1:0] r4_reg;
    // Stage 5: partial products on the low and high halves of den and num.
    logic signed [PW-1:0] l1lo_reg, l1hi_reg, l2lo_reg, l2hi_reg;
    logic signed [PW-1:0] a1alo_reg, a1ahi_reg, a1blo_reg, a1bhi_reg;
    logic signed [PW-1:0] a2alo_reg, a2ahi_reg, a2blo_reg, a2bhi_reg;
    logic signed [PW-1:0] rhslo_reg, rhshi_reg;
    logic signed [SW-1:0] lhs_reg;
    logic ok5_reg;
    // Stage 6: sums.
    logic signed [SW-1:0] l16_reg, l26_reg, a16_reg, a26_reg;
    logic ok6_reg;

    logic signed [DW-1:0] den_next, num_next;
    logic signed [HW:0] den_lo, num_lo;
    logic signed [HHW-1:0] den_hi, num_hi;
    logic signed [RW:0] rng5;

    always_comb
    begin
        den_next = DW'(d2_reg[0] * n_reg[0]) + DW'(d2_reg[1] * n_reg[1])
                 + DW'(d2_reg[2] * n_reg[2]);
        num_next = DW'(w2_reg[0] * n_reg[0]) + DW'(w2_reg[1] * n_reg[1])
                 + DW'(w2_reg[2] * n_reg[2]);
    end

    assign den_lo = $signed({1'b0, den4_reg[HW-1:0]});
    assign den_hi = den4_reg[DW-1:HW];
    assign num_lo = $signed({1'b0, num4_reg[HW-1:0]});
    assign num_hi = num4_reg[DW-1:HW];
    assign rng5 = $signed({1'b0, r4_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= EW'(p1[k]) - EW'(p0[k]);
                e2_reg[k] <= EW'(p3[k]) - EW'(p0[k]);
                w_reg[k] <= EW'(p0[k]) - EW'(o[k]);
                d1_reg[k] <= d[k];
            end
            r1_reg <= range_in;

            n_reg[0] <= NW'(e1_reg[1] * e2_reg[2]) - NW'(e1_reg[2] * e2_reg[1]);
            n_reg[1] <= NW'(e1_reg[2] * e2_reg[0]) - NW'(e1_reg[0] * e2_reg[2]);
            n_reg[2] <= NW'(e1_reg[0] * e2_reg[1]) - NW'(e1_reg[1] * e2_reg[0]);
            e1b_reg <= e1_reg;
            e2b_reg <= e2_reg;
            w2_reg <= w_reg;
            d2_reg <= d1_reg;
            r2_reg <= r1_reg;

            den_reg <= den_next;
            num_reg <= num_next;
            l1s_reg <= LW'(e1b_reg[0] * e1b_reg[0]) + LW'(e1b_reg[1] * e1b_reg[1])
                     + LW'(e1b_reg[2] * e1b_reg[2]);
            l2s_reg <= LW'(e2b_reg[0] * e2b_reg[0]) + LW'(e2b_reg[1] * e2b_reg[1])
                     + LW'(e2b_reg[2] * e2b_reg[2]);
            rp1_reg <= -(LW'(w2_reg[0] * e1b_reg[0]) + LW'(w2_reg[1] * e1b_reg[1])
                     + LW'(w2_reg[2] * e1b_reg[2]));
            rp2_reg <= -(LW'(w2_reg[0] * e2b_reg[0]) + LW'(w2_reg[1] * e2b_reg[1])
                     + LW'(w2_reg[2] * e2b_reg[2]));
            de1_reg <= DEW'(d2_reg[0] * e1b_reg[0]) + DEW'(d2_reg[1] * e1b_reg[1])
                     + DEW'(d2_reg[2] * e1b_reg[2]);
            de2_reg <= DEW'(d2_reg[0] * e2b_reg[0]) + DEW'(d2_reg[1] * e2b_reg[1])
                     + DEW'(d2_reg[2] * e2b_reg[2]);
            r3_reg <= r2_reg;

            den4_reg <= den_reg[DW-1] ? -den_reg : den_reg;
            num4_reg <= den_reg[DW-1] ? -num_reg : num_reg;
            ok4_reg <= (den_reg != '0);
            l1s4_reg <= l1s_reg;
            l2s4_reg <= l2s_reg;
            rp14_reg <= rp1_reg;
            rp24_reg <= rp2_reg;
            de14_reg <= de1_reg;
            de24_reg <= de2_reg;
            r4_reg <= r3_reg;

            l1lo_reg <= PW'(den_lo * l1s4_reg);
            l1hi_reg <= PW'(den_hi * l1s4_reg);
            l2lo_reg <= PW'(den_lo * l2s4_reg);
            l2hi_reg <= PW'(den_hi * l2s4_reg);
            a1alo_reg <= PW'(rp14_reg * den_lo);
            a1ahi_reg <= PW'(rp14_reg * den_hi);
            a1blo_reg <= PW'(num_lo * de14_reg);
            a1bhi_reg <= PW'(num_hi * de14_reg);
            a2alo_reg <= PW'(rp24_reg * den_lo);
            a2ahi_reg <= PW'(rp24_reg * den_hi);
            a2blo_reg <= PW'(num_lo * de24_reg);
            a2bhi_reg <= PW'(num_hi * de24_reg);
            rhslo_reg <= PW'(den_lo * rng5);
            rhshi_reg <= PW'(den_hi * rng5);
            lhs_reg <= SW'(num4_reg) <<< FB;
            ok5_reg <= ok4_reg && !num4_reg[DW-1];

            l16_reg <= (SW'(l1hi_reg) <<< HW) + SW'(l1lo_reg);
            l26_reg <= (SW'(l2hi_reg) <<< HW) + SW'(l2lo_reg);
            a16_reg <= ((SW'(a1ahi_reg) + SW'(a1bhi_reg)) <<< HW)
                     + SW'(a1alo_reg) + SW'(a1blo_reg);
            a26_reg <= ((SW'(a2ahi_reg) + SW'(a2bhi_reg)) <<< HW)
                     + SW'(a2alo_reg) + SW'(a2blo_reg);
            ok6_reg <= ok5_reg && !(lhs_reg > (SW'(rhshi_reg) <<< HW) + SW'(rhslo_reg));

            hit <= ok6_reg && !a16_reg[SW-1] && !(a16_reg > l16_reg)
                 && !a26_reg[SW-1] && !(a26_reg > l26_reg);
        end
    end
endmodule
`default_nettype wire
